### rtl/bwf_pkg.sv
package bwf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int RING_ROWS   = 8;
    localparam int WINDOW_SIZE = 5;
    localparam int TAPS        = WINDOW_SIZE * WINDOW_SIZE;
    localparam int CENTER_TAP  = TAPS / 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int RING_W      = $clog2(RING_ROWS);
    localparam int ADDR_W      = RING_W + COL_W;
    localparam int DEPTH       = RING_ROWS * MAX_WIDTH;
    localparam int FW_W        = COL_W + 1;
    localparam int FH_W        = 13;
    localparam int ROW_W       = 13;
    localparam int CNT_W       = FW_W + FH_W - 1;
    localparam int TAP_W       = $clog2(TAPS + 1);
    localparam int WGT_W       = 16;
    localparam int W_W         = 31;
    localparam int NUM_W       = 43;
    localparam int DEN_W       = 35;
    localparam logic [WGT_W-1:0] Q15_ONE = 16'd32768;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RATE   = 3'd2;
    localparam logic [2:0] REG_DIST1  = 3'd3;
    localparam logic [2:0] REG_DIST2  = 3'd4;
    localparam logic [2:0] REG_DIST4  = 3'd5;
    localparam logic [2:0] REG_DIST5  = 3'd6;
    localparam logic [2:0] REG_DIST8  = 3'd7;

    typedef logic [15:0] frac_table_t [256];

    function automatic frac_table_t build_frac();
        frac_table_t tbl;
        logic [63:0] t;
        t = 64'd2147483648;
        for (int f = 0; f < 256; f++)
        begin
            tbl[f] = 16'((t + 64'd32768) >> 16);
            t = (t * 64'd4283353945 + 64'd2147483648) >> 32;
        end
        return tbl;
    endfunction

    localparam frac_table_t FRAC_TABLE = build_frac();

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_TOTAL, S_WRITE, S_DECIDE,
        S_READ, S_STREAM, S_WAIT, S_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic tap_valid;
        logic finish;
    } kern_ctl_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } kern_stat_t;

endpackage

### rtl/bilateral_window_filter.sv
// Filters a raster stream of 8-bit pixels with a 5x5 bilateral kernel, clamping at the frame
// edges. Each transfer holds in_stall high until it is done; one that produces a result also
// waits while the previous result is held at the output, and its 25 window pixels are read
// one per cycle from the row memory, weighted one per cycle, and the quotient is found one bit
// per cycle. Result k of a frame follows input k+2*W+2, and drain items (op = 1) flush the
// final 2*W+2 results once the frame is complete.
module bilateral_window_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  pixel_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_out,
    output logic        frame_end,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bwf_pkg::*;

    state_t state_reg, state_next;

    logic [10:0] width_cfg_reg;
    logic [12:0] height_cfg_reg;
    logic [11:0] rate_reg;
    logic [15:0] wd1_reg, wd2_reg, wd4_reg, wd5_reg, wd8_reg;

    logic             op_reg;
    logic [7:0]       pix_reg;
    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    logic [CNT_W-1:0] total_reg, in_cnt_reg, out_cnt_reg;
    logic [COL_W-1:0] in_col_reg, out_x_reg;
    logic [ROW_W-1:0] in_row_reg, out_y_reg;
    logic [TAP_W-1:0] rd_cnt_reg, cap_cnt_reg, st_cnt_reg;
    logic [2:0]       rkx_reg, rky_reg, skx_reg, sky_reg;
    logic             rd_valid_reg;
    logic [7:0]       win_reg [TAPS];
    logic [7:0]       center_reg;
    logic [7:0]       q_reg;
    logic             out_valid_reg, frame_end_reg;
    logic [7:0]       pixel_out_reg;

    logic             wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]       rd_data;
    logic             emit, can_write, out_free, last_out;
    logic [CNT_W:0]   lag_sum;
    logic signed [ROW_W+1:0] ny;
    logic signed [COL_W+2:0] nx;
    logic [ROW_W-1:0] ny_c;
    logic [COL_W-1:0] nx_c;
    logic [1:0]       dx, dy;
    logic [WGT_W-1:0] sw_raw, sw_sat;
    kern_ctl_t        kctl;
    kern_stat_t       kstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= 11'd640;
            height_cfg_reg <= 13'd480;
            rate_reg       <= 12'd7;
            wd1_reg        <= 16'd23006;
            wd2_reg        <= 16'd19875;
            wd4_reg        <= 16'd16158;
            wd5_reg        <= 16'd14864;
            wd8_reg        <= 16'd12055;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_cfg_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_cfg_reg <= cfg_data[12:0];
                REG_RATE:   rate_reg       <= cfg_data[11:0];
                REG_DIST1:  wd1_reg        <= cfg_data;
                REG_DIST2:  wd2_reg        <= cfg_data;
                REG_DIST4:  wd4_reg        <= cfg_data;
                REG_DIST5:  wd5_reg        <= cfg_data;
                REG_DIST8:  wd8_reg        <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign can_write = !op_reg && (in_cnt_reg < total_reg);
    assign lag_sum   = {1'b0, out_cnt_reg} + (CNT_W + 1)'({fw_reg, 1'b0}) + (CNT_W + 1)'(2);
    assign emit      = !((out_cnt_reg >= total_reg)
                      || ((in_cnt_reg < total_reg) && ({1'b0, in_cnt_reg} <= lag_sum)));
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_out  = (out_cnt_reg + CNT_W'(1)) >= total_reg;

    always_comb
    begin
        ny = $signed({2'b00, out_y_reg}) + $signed((ROW_W + 2)'(rky_reg)) - (ROW_W + 2)'(2);
        nx = $signed({3'b000, out_x_reg}) + $signed((COL_W + 3)'(rkx_reg)) - (COL_W + 3)'(2);
        if (ny < 0)
            ny_c = '0;
        else if (ny >= $signed({2'b00, fh_reg}))
            ny_c = ROW_W'(fh_reg - FH_W'(1));
        else
            ny_c = ny[ROW_W-1:0];
        if (nx < 0)
            nx_c = '0;
        else if (nx >= $signed({2'b00, fw_reg}))
            nx_c = COL_W'(fw_reg - FW_W'(1));
        else
            nx_c = nx[COL_W-1:0];
    end

    assign wr_en   = (state_reg == S_WRITE) && can_write;
    assign wr_addr = {in_row_reg[RING_W-1:0], in_col_reg};
    assign rd_en   = (state_reg == S_READ) && (rd_cnt_reg < TAP_W'(TAPS));
    assign rd_addr = {ny_c[RING_W-1:0], nx_c};

    bwf_line_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pix_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        dx = (skx_reg >= 3'd2) ? 2'(skx_reg - 3'd2) : 2'(3'd2 - skx_reg);
        dy = (sky_reg >= 3'd2) ? 2'(sky_reg - 3'd2) : 2'(3'd2 - sky_reg);
        case ({dx, dy})
            4'b0000: sw_raw = Q15_ONE;
            4'b0100, 4'b0001: sw_raw = wd1_reg;
            4'b0101: sw_raw = wd2_reg;
            4'b1000, 4'b0010: sw_raw = wd4_reg;
            4'b1001, 4'b0110: sw_raw = wd5_reg;
            4'b1010: sw_raw = wd8_reg;
            default: sw_raw = '0;
        endcase
        sw_sat = (sw_raw > Q15_ONE) ? Q15_ONE : sw_raw;
    end

    assign kctl.clear     = (state_reg == S_DECIDE);
    assign kctl.tap_valid = (state_reg == S_STREAM);
    assign kctl.finish    = (state_reg == S_STREAM) && (st_cnt_reg == TAP_W'(TAPS - 1));

    bwf_kernel u_kernel (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (kctl),
        .tap_pixel  (win_reg[0]),
        .center     (center_reg),
        .spatial    (sw_sat),
        .range_rate (rate_reg),
        .stat       (kstat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_START;
            S_START:  state_next = S_TOTAL;
            S_TOTAL:  state_next = S_WRITE;
            S_WRITE:  state_next = S_DECIDE;
            S_DECIDE: state_next = emit ? S_READ : S_IDLE;
            S_READ:
                if (rd_cnt_reg == TAP_W'(TAPS) && !rd_valid_reg)
                    state_next = S_STREAM;
            S_STREAM:
                if (st_cnt_reg == TAP_W'(TAPS - 1))
                    state_next = S_WAIT;
            S_WAIT:   if (kstat.done) state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= 11'd640;
            fh_reg        <= 13'd480;
            total_reg     <= '0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            rd_cnt_reg    <= '0;
            cap_cnt_reg   <= '0;
            st_cnt_reg    <= '0;
            rkx_reg       <= '0;
            rky_reg       <= '0;
            skx_reg       <= '0;
            sky_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_START:
                    if (in_cnt_reg == '0 && out_cnt_reg == '0)
                    begin
                        if (width_cfg_reg == '0)
                            fw_reg <= FW_W'(1);
                        else if (width_cfg_reg > FW_W'(MAX_WIDTH))
                            fw_reg <= FW_W'(MAX_WIDTH);
                        else
                            fw_reg <= width_cfg_reg;
                        if (height_cfg_reg == '0)
                            fh_reg <= FH_W'(1);
                        else if (height_cfg_reg > FH_W'(MAX_HEIGHT))
                            fh_reg <= FH_W'(MAX_HEIGHT);
                        else
                            fh_reg <= height_cfg_reg;
                    end
                S_TOTAL:
                    total_reg <= CNT_W'(fw_reg * fh_reg);
                S_WRITE:
                    if (can_write)
                    begin
                        in_cnt_reg <= in_cnt_reg + CNT_W'(1);
                        if ({1'b0, in_col_reg} + FW_W'(1) >= fw_reg)
                        begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + COL_W'(1);
                        end
                    end
                S_DECIDE:
                begin
                    rd_cnt_reg  <= '0;
                    cap_cnt_reg <= '0;
                    st_cnt_reg  <= '0;
                    rkx_reg     <= '0;
                    rky_reg     <= '0;
                    skx_reg     <= '0;
                    sky_reg     <= '0;
                end
                S_READ:
                    if (rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + TAP_W'(1);
                        if (rkx_reg == 3'd4)
                        begin
                            rkx_reg <= '0;
                            rky_reg <= rky_reg + 3'd1;
                        end
                        else
                        begin
                            rkx_reg <= rkx_reg + 3'd1;
                        end
                    end
                S_STREAM:
                begin
                    st_cnt_reg <= st_cnt_reg + TAP_W'(1);
                    if (skx_reg == 3'd4)
                    begin
                        skx_reg <= '0;
                        sky_reg <= sky_reg + 3'd1;
                    end
                    else
                    begin
                        skx_reg <= skx_reg + 3'd1;
                    end
                end
                S_OUT:
                    if (out_free)
                    begin
                        if (last_out)
                        begin
                            in_cnt_reg  <= '0;
                            out_cnt_reg <= '0;
                            in_col_reg  <= '0;
                            in_row_reg  <= '0;
                            out_x_reg   <= '0;
                            out_y_reg   <= '0;
                        end
                        else
                        begin
                            out_cnt_reg <= out_cnt_reg + CNT_W'(1);
                            if ({1'b0, out_x_reg} + FW_W'(1) >= fw_reg)
                            begin
                                out_x_reg <= '0;
                                out_y_reg <= out_y_reg + ROW_W'(1);
                            end
                            else
                            begin
                                out_x_reg <= out_x_reg + COL_W'(1);
                            end
                        end
                    end
                default: ;
            endcase
            if (rd_valid_reg)
            begin
                cap_cnt_reg <= cap_cnt_reg + TAP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg  <= op;
            pix_reg <= pixel_in;
        end
        if (rd_valid_reg || state_reg == S_STREAM)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[TAPS - 1] <= rd_valid_reg ? rd_data : win_reg[0];
        end
        if (rd_valid_reg && cap_cnt_reg == TAP_W'(CENTER_TAP))
        begin
            center_reg <= rd_data;
        end
        if (state_reg == S_WAIT && kstat.done)
        begin
            q_reg <= kstat.quotient;
        end
        if (state_reg == S_OUT && out_free)
        begin
            pixel_out_reg <= q_reg;
            frame_end_reg <= last_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

### rtl/bwf_line_ram.sv
module bwf_line_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [bwf_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [bwf_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import bwf_pkg::*;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bwf_kernel.sv
module bwf_kernel (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bwf_pkg::kern_ctl_t       ctl,
    input  logic [7:0]               tap_pixel,
    input  logic [7:0]               center,
    input  logic [bwf_pkg::WGT_W-1:0] spatial,
    input  logic [11:0]              range_rate,
    output bwf_pkg::kern_stat_t      stat
);
    import bwf_pkg::*;

    logic [7:0]       diff;
    logic [19:0]      expo;
    logic [WGT_W-1:0] rw;
    logic [WGT_W-1:0] rw_reg, sw_reg;
    logic [7:0]       p1_reg, p2_reg;
    logic             v1_reg, v2_reg;
    logic [W_W-1:0]   w_reg;
    logic [NUM_W-1:0] num_reg, rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] trial;
    logic             fin_reg, div_reg, done_reg;
    logic [2:0]       bit_reg;
    logic [7:0]       q_reg;

    assign diff  = (tap_pixel > center) ? tap_pixel - center : center - tap_pixel;
    assign expo  = diff * range_rate;
    assign rw    = (expo[19:12] != 8'd0) ? '0 : (FRAC_TABLE[expo[7:0]] >> expo[11:8]);
    assign trial = NUM_W'({8'd0, den_reg}) << bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            fin_reg  <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            v1_reg   <= ctl.tap_valid;
            v2_reg   <= v1_reg;
            done_reg <= 1'b0;
            if (ctl.finish)
            begin
                fin_reg <= 1'b1;
            end
            else if (fin_reg && !v1_reg && !v2_reg)
            begin
                fin_reg <= 1'b0;
                div_reg <= 1'b1;
                bit_reg <= 3'd7;
            end
            else if (div_reg)
            begin
                bit_reg <= bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    div_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg <= rw;
        sw_reg <= spatial;
        p1_reg <= tap_pixel;
        w_reg  <= W_W'(sw_reg * rw_reg);
        p2_reg <= p1_reg;
        if (ctl.clear)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (v2_reg)
        begin
            num_reg <= num_reg + NUM_W'(w_reg * p2_reg);
            den_reg <= den_reg + DEN_W'(w_reg);
        end
        if (fin_reg && !v1_reg && !v2_reg)
        begin
            rem_reg <= num_reg;
            q_reg   <= '0;
        end
        else if (div_reg && rem_reg >= trial)
        begin
            rem_reg          <= rem_reg - trial;
            q_reg[bit_reg]   <= 1'b1;
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = q_reg;

endmodule
